// ----- design/fpsqrt_pkg.sv -----
// Package for the fixed-point square root core: word format constants and the
// record that travels down the row of root cells. No dependencies.
`default_nettype none

package fpsqrt_pkg;

  // Input and result field widths.
  localparam int unsigned RADICAND_BITS = 64;
  localparam int unsigned ROOT_BITS     = 46;

  // Fixed-point format of the word that is rooted.
  localparam int unsigned WORD_BITS     = 64;
  localparam int unsigned FRACTION_BITS = 28;

  // One cell per bit pair; the remainder stays below 2*root + 1.
  localparam int unsigned STEPS         = WORD_BITS / 2;
  localparam int unsigned HALF_FRAC     = FRACTION_BITS / 2;
  localparam int unsigned REM_BITS      = STEPS + 2;
  localparam int unsigned SHIFTED_BITS  = STEPS + HALF_FRAC + ROOT_BITS;

  // State of one beat as it leaves a cell.
  typedef struct packed {
    logic                 valid;
    logic                 neg;
    logic [WORD_BITS-1:0] bits;
    logic [REM_BITS-1:0]  rem;
    logic [STEPS-1:0]     root;
  } sqrt_cell_t;

endpackage

`default_nettype wire

// ----- design/fpsqrt_cell.sv -----
// One restoring square root cell: brings down one bit pair and decides one root bit.
// Depends on fpsqrt_pkg.
`default_nettype none

module fpsqrt_cell
  import fpsqrt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire sqrt_cell_t prev_i,
  output sqrt_cell_t      next_o
);

  logic [1:0]           pair;
  logic [REM_BITS-1:0]  rem_sh;
  logic [REM_BITS-1:0]  trial;
  logic                 fits;

  logic                 valid_q;
  logic                 neg_q,  neg_d;
  logic [WORD_BITS-1:0] bits_q, bits_d;
  logic [REM_BITS-1:0]  rem_q,  rem_d;
  logic [STEPS-1:0]     root_q, root_d;

  // Bring down the next pair and test 4*root+1 against the remainder.
  always_comb begin
    pair   = prev_i.bits[WORD_BITS-1 -: 2];
    rem_sh = {prev_i.rem[REM_BITS-3:0], pair};
    trial  = {1'b0, prev_i.root[STEPS-2:0], 1'b0, 1'b1};
    fits   = (rem_sh >= trial);
    rem_d  = fits ? (rem_sh - trial) : rem_sh;
    root_d = {prev_i.root[STEPS-2:0], fits};
    bits_d = {prev_i.bits[WORD_BITS-3:0], 2'b00};
    neg_d  = prev_i.neg;
  end

  // Valid flag of the beat held in this cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= prev_i.valid;
    end
  end

  // Payload of the beat held in this cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q  <= neg_d;
      bits_q <= bits_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign next_o = '{valid: valid_q, neg: neg_q, bits: bits_q, rem: rem_q, root: root_q};

  // The remainder of a restoring step never exceeds twice the partial root.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (rem_q <= {1'b0, root_q, 1'b0}))
    else $error("fpsqrt_cell: remainder above twice the partial root");

endmodule

`default_nettype wire

// ----- design/fpsqrt_out.sv -----
// Output register: scales the integer root into the fixed-point format and
// forces the root to zero for a negative radicand. Depends on fpsqrt_pkg.
`default_nettype none

module fpsqrt_out
  import fpsqrt_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire sqrt_cell_t   last_i,
  output logic              valid_o,
  output logic [ROOT_BITS-1:0] root_o,
  output logic              negative_error_o
);

  logic [SHIFTED_BITS-1:0] shifted;
  logic [ROOT_BITS-1:0]    root_d, root_q;
  logic                    valid_q;
  logic                    neg_q;

  // Shift by half the fraction bits and keep the low field bits.
  always_comb begin
    shifted = SHIFTED_BITS'(last_i.root) << HALF_FRAC;
    root_d  = last_i.neg ? '0 : shifted[ROOT_BITS-1:0];
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= last_i.valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= root_d;
      neg_q  <= last_i.neg;
    end
  end

  assign valid_o          = valid_q;
  assign root_o           = root_q;
  assign negative_error_o = neg_q;

  // A negative radicand always delivers a zero root.
  a_neg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && neg_q) |-> (root_q == '0))
    else $error("fpsqrt_out: nonzero root with negative error");

endmodule

`default_nettype wire

// ----- design/fixed_point_square_root_core.sv -----
// Fixed-point square root core: a row of bit-pair root cells and an output register.
// Depends on fpsqrt_pkg, fpsqrt_cell and fpsqrt_out.
//
// Usage:
//   Input channel: in_valid_i, in_stall_o, in_radicand_i. A beat is taken at a
//   rising edge with in_valid_i high and in_stall_o low. The radicand is a
//   two's complement word with FRACTION_BITS fraction bits.
//   Output channel: out_valid_o, out_stall_i, out_root_o, out_negative_error_o.
//   out_root_o is fixed-point with FRACTION_BITS fraction bits in ROOT_BITS; a
//   negative radicand gives a zero root with out_negative_error_o set.
//   Pipeline: one cell per bit pair followed by the output register.
//   Throughput: one beat per cycle while the row is not stalled; every cell
//   hands its beat to the next cell in each cycle that the row advances.
//   Stall: the whole row holds while a result waits under out_stall_i, and
//   in_stall_o is raised in those cycles; otherwise the input is always open.
//   Reset: rst_ni clears every valid flag at once, so the row is empty and
//   ready in the first cycle after reset.
`default_nettype none

module fixed_point_square_root_core
  import fpsqrt_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [RADICAND_BITS-1:0] in_radicand_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [ROOT_BITS-1:0]          out_root_o,
  output logic                          out_negative_error_o
);

  sqrt_cell_t stage_s [STEPS+1];
  logic       advance;

  // The row moves unless a finished result is held by the receiver.
  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;

  // Head of the row: the word to be rooted with an empty remainder and root.
  assign stage_s[0] = '{valid: in_valid_i,
                        neg:   in_radicand_i[WORD_BITS-1],
                        bits:  in_radicand_i[WORD_BITS-1:0],
                        rem:   '0,
                        root:  '0};

  // One cell per bit pair.
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    fpsqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .prev_i (stage_s[k]),
      .next_o (stage_s[k+1])
    );
  end

  // Scaling and output register.
  fpsqrt_out u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (advance),
    .last_i           (stage_s[STEPS]),
    .valid_o          (out_valid_o),
    .root_o           (out_root_o),
    .negative_error_o (out_negative_error_o)
  );

  // The input is held back only while a result sits stalled at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("core: input stalled without a stalled result");

  // A stalled result keeps the last cell's beat in place as well.
  a_row_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(stage_s[STEPS].valid))
    else $error("core: last cell moved during an output stall");

endmodule

`default_nettype wire
